// ===== sv/sem_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and register codes for the Sobel edge magnitude block.
// Used by the line buffer, the channel lanes and the top level.
package sem_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int RST_WIDTH      = 1024;
	localparam int RST_HEIGHT     = 1024;

	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int SQRT_STEPS = 8;
	// gradient stage, sum of squares stage, then one stage per root bit
	localparam int LANE_LAT   = 2 + SQRT_STEPS;

	// largest s whose rounded root still fits below the clamp
	localparam logic [20:0] MAG_CLAMP_S = 21'd64770;
	localparam logic [7:0]  MAG_MAX     = 8'd255;

	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} edge_mask_t;

	// [column][row], column 0 is the left one, row 0 the top one
	typedef logic [2:0][2:0][PIX_W-1:0] pix_win_t;
	typedef logic [2:0][2:0][CH_W-1:0]  chan_win_t;

endpackage

// ===== sv/sem_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel and drain beats in, edge magnitude beats out.
// No dependencies.
interface sem_pix_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, req_type, red, green, blue, input ready);
	modport sink(input valid, req_type, red, green, blue, output ready);
endinterface

interface sem_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] edge_red;
	logic [7:0] edge_green;
	logic [7:0] edge_blue;
	logic       frame_last;

	modport source(output valid, edge_red, edge_green, edge_blue, frame_last, input ready);
	modport sink(input valid, edge_red, edge_green, edge_blue, frame_last, output ready);
endinterface

// ===== sv/sem_linebuf.sv =====
`timescale 1ns / 1ps
// Two-row line buffer in one memory plus the 3x3 pixel window register.
// Depends on sem_pkg.
module sem_linebuf #(
	parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH,
	parameter int CW        = $clog2(MAX_WIDTH)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    push_s0,
	input  logic [CW-1:0]           col_s0,
	input  logic [sem_pkg::PIX_W-1:0] pix_s0,
	output sem_pkg::pix_win_t       win_s2
);
	import sem_pkg::*;

	// {row two above, row above}
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_s1;

	logic             push_s1;
	logic [CW-1:0]    col_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_pix_s1;
	logic [PIX_W-1:0] fwd_mid_s1;
	logic [PIX_W-1:0] mid_s1;
	logic [PIX_W-1:0] top_s1;

	// one-pixel rows hit the same entry on back-to-back beats: take the write data
	assign mid_s1 = fwd_s1 ? fwd_pix_s1 : rd_s1[PIX_W-1:0];
	assign top_s1 = fwd_s1 ? fwd_mid_s1 : rd_s1[2*PIX_W-1:PIX_W];

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem[col_s0];
			if (push_s1) begin
				mem[col_s1] <= {mid_s1, pix_s1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_s1 <= 1'b0;
			fwd_s1  <= 1'b0;
		end else if (adv) begin
			push_s1 <= push_s0;
			fwd_s1  <= push_s1 && push_s0 && (col_s1 == col_s0);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1     <= col_s0;
			pix_s1     <= pix_s0;
			fwd_pix_s1 <= pix_s1;
			fwd_mid_s1 <= mid_s1;
			if (push_s1) begin
				win_s2[0]    <= win_s2[1];
				win_s2[1]    <= win_s2[2];
				win_s2[2][0] <= top_s1;
				win_s2[2][1] <= mid_s1;
				win_s2[2][2] <= pix_s1;
			end
		end
	end

endmodule

// ===== sv/sem_lane.sv =====
`timescale 1ns / 1ps
// One color channel: masked Sobel gradients, sum of squares, bit-per-stage rounded root.
// Depends on sem_pkg.
module sem_lane (
	input  logic                clk,
	input  logic                adv,
	input  sem_pkg::chan_win_t  win,
	input  sem_pkg::edge_mask_t mask,
	output logic [sem_pkg::CH_W-1:0] mag
);
	import sem_pkg::*;

	chan_win_t          pm;
	logic [9:0]         rsum, lsum, bsum, tsum;
	logic signed [11:0] gx_s3, gy_s3;
	logic signed [20:0] gx_e, gy_e;
	logic [20:0]        sum_s4;
	logic [7:0]         root_st [1:SQRT_STEPS];
	logic [15:0]        val_st  [1:SQRT_STEPS];
	logic               big_st  [1:SQRT_STEPS];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 3; r++) begin
				if ((mask.left && c == 0) || (mask.right && c == 2) ||
				    (mask.top && r == 0) || (mask.bottom && r == 2)) begin
					pm[c][r] = '0;
				end else begin
					pm[c][r] = win[c][r];
				end
			end
		end
		rsum = 10'(pm[2][0]) + {1'b0, pm[2][1], 1'b0} + 10'(pm[2][2]);
		lsum = 10'(pm[0][0]) + {1'b0, pm[0][1], 1'b0} + 10'(pm[0][2]);
		bsum = 10'(pm[0][2]) + {1'b0, pm[1][2], 1'b0} + 10'(pm[2][2]);
		tsum = 10'(pm[0][0]) + {1'b0, pm[1][0], 1'b0} + 10'(pm[2][0]);
	end

	// widen before squaring so the products keep all their bits
	assign gx_e = {{9{gx_s3[11]}}, gx_s3};
	assign gy_e = {{9{gy_s3[11]}}, gy_s3};

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s3  <= signed'({2'b00, rsum}) - signed'({2'b00, lsum});
			gy_s3  <= signed'({2'b00, bsum}) - signed'({2'b00, tsum});
			sum_s4 <= unsigned'(gx_e * gx_e) + unsigned'(gy_e * gy_e);
		end
	end

	// largest r with r*(r-1) < s, one bit per stage from the top
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic [7:0]  root_in;
		logic [15:0] val_in;
		logic        big_in;
		logic [7:0]  t;
		logic [15:0] prod;

		if (k == 0) begin : g_first
			assign root_in = '0;
			assign val_in  = sum_s4[15:0];
			assign big_in  = sum_s4 > MAG_CLAMP_S;
		end else begin : g_next
			assign root_in = root_st[k];
			assign val_in  = val_st[k];
			assign big_in  = big_st[k];
		end

		assign t    = root_in | (8'h80 >> k);
		assign prod = {8'h00, t} * {8'h00, t - 8'd1};

		always_ff @(posedge clk) begin
			if (adv) begin
				root_st[k+1] <= (prod < val_in) ? t : root_in;
				val_st[k+1]  <= val_in;
				big_st[k+1]  <= big_in;
			end
		end
	end

	assign mag = big_st[SQRT_STEPS] ? MAG_MAX : root_st[SQRT_STEPS];

endmodule

// ===== sv/sobel_edge_magnitude_rgb.sv =====
`timescale 1ns / 1ps
// Sobel edge magnitude on an RGB raster stream. One pixel or drain beat is taken per
// clock while the output side keeps up; a result leaves once the beat that completes its
// 3x3 neighborhood, which is the pixel one row and one column past it, has gone through
// the line buffer, the window register and the lanes. The only exception: in a one-row
// frame the first drain beat holds the input while a zero push is inserted. The rate
// is set by the line buffer, a single memory that is read and written once per cycle,
// and by the three channel lanes that each finish one root per cycle. Stale line
// buffer contents are never used, so no clearing pass runs after reset. Writing either
// register restarts the frame. Depends on sem_pkg, sem_if, sem_linebuf and sem_lane.
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH  = sem_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = sem_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	sem_pix_if.sink     pix,
	sem_res_if.source   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sem_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam logic [CW-1:0] RST_WM1 =
		CW'(((RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH) - 1);
	localparam logic [RW-1:0] RST_HM1 =
		RW'(((RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT) - 1);

	logic [10:0]   width_q;
	logic [12:0]   height_q;
	logic [CW-1:0] wm1_q, wm1_nxt;
	logic [RW-1:0] hm1_q, hm1_nxt;
	logic [31:0]   wv, hv;
	logic          cfg_wr;

	logic [CW-1:0] in_col_q, out_col_q;
	logic [RW-1:0] in_row_q, out_row_q;
	logic [CW:0]   lag_q;
	logic          full_q, in_done_q, owe_q;

	logic          adv, acc, take, drn, push, emit, owe_set, last;
	logic [PIX_W-1:0] pix_s0;
	edge_mask_t    mask_s0, mask_s1, mask_s2;
	logic          emit_s1, last_s1, emit_s2, last_s2;
	logic [LANE_LAT-1:0] vld_q, last_q;

	pix_win_t  win_s2;
	chan_win_t cwin [3];
	logic [7:0] mag [3];

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(height_q) : 32'(width_q);
	assign wv = 32'(pwdata[10:0]);
	assign hv = 32'(pwdata[12:0]);
	assign wm1_nxt = (wv == 32'd0) ? '0 :
		(wv > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(wv - 32'd1);
	assign hm1_nxt = (hv == 32'd0) ? '0 :
		(hv > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) : RW'(hv - 32'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'(RST_WIDTH);
			height_q <= 13'(RST_HEIGHT);
			wm1_q    <= RST_WM1;
			hm1_q    <= RST_HM1;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_FRAME_WIDTH) begin
				width_q <= pwdata[10:0];
				wm1_q   <= wm1_nxt;
			end else begin
				height_q <= pwdata[12:0];
				hm1_q    <= hm1_nxt;
			end
		end
	end

	// input stage decisions
	assign adv       = !res.valid || res.ready;
	assign pix.ready = adv && !owe_q;
	assign acc       = pix.valid && pix.ready;
	assign take      = acc && !pix.req_type && !in_done_q;
	assign drn       = acc && pix.req_type && in_done_q;
	// a one-row frame is short of one beat at its first drain: insert a zero push
	assign owe_set   = drn && !full_q;
	assign push      = take || drn || (owe_q && adv);
	assign emit      = ((take || drn) && full_q) || (owe_q && adv);
	assign last      = (out_row_q == hm1_q) && (out_col_q == wm1_q);
	assign pix_s0    = take ? {pix.red, pix.green, pix.blue} : '0;

	assign mask_s0.top    = (out_row_q == '0);
	assign mask_s0.bottom = (out_row_q == hm1_q);
	assign mask_s0.left   = (out_col_q == '0);
	assign mask_s0.right  = (out_col_q == wm1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lag_q     <= '0;
			full_q    <= 1'b0;
			in_done_q <= 1'b0;
			owe_q     <= 1'b0;
		end else begin
			if (adv) begin
				owe_q <= owe_set;
			end
			if (push) begin
				in_col_q <= (in_col_q == wm1_q) ? '0 : in_col_q + 1'b1;
				if (!full_q) begin
					if (lag_q == ({1'b0, wm1_q} + (CW+1)'(1))) begin
						full_q <= 1'b1;
					end else begin
						lag_q <= lag_q + 1'b1;
					end
				end
			end
			if (take && in_col_q == wm1_q) begin
				if (in_row_q == hm1_q) begin
					in_done_q <= 1'b1;
				end else begin
					in_row_q <= in_row_q + 1'b1;
				end
			end
			if (emit) begin
				if (last) begin
					// frame done: restart both positions
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					lag_q     <= '0;
					full_q    <= 1'b0;
					in_done_q <= 1'b0;
				end else if (out_col_q == wm1_q) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
			if (cfg_wr) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				lag_q     <= '0;
				full_q    <= 1'b0;
				in_done_q <= 1'b0;
				owe_q     <= 1'b0;
			end
		end
	end

	sem_linebuf #(
		.MAX_WIDTH(MAX_WIDTH),
		.CW       (CW)
	) u_linebuf (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.push_s0(push),
		.col_s0 (in_col_q),
		.pix_s0 (pix_s0),
		.win_s2 (win_s2)
	);

	// beat control follows the window through the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s1 <= 1'b0;
			emit_s2 <= 1'b0;
			vld_q   <= '0;
		end else if (adv) begin
			emit_s1 <= emit;
			emit_s2 <= emit_s1;
			vld_q   <= {vld_q[LANE_LAT-2:0], emit_s2};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s1 <= last;
			mask_s1 <= mask_s0;
			last_s2 <= last_s1;
			mask_s2 <= mask_s1;
			last_q  <= {last_q[LANE_LAT-2:0], last_s2};
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_lane
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					cwin[c][i][j] = win_s2[i][j][PIX_W-1-CH_W*c -: CH_W];
				end
			end
		end

		sem_lane u_lane (
			.clk (clk),
			.adv (adv),
			.win (cwin[c]),
			.mask(mask_s2),
			.mag (mag[c])
		);
	end

	// merge the three lanes into one result beat
	assign res.valid      = vld_q[LANE_LAT-1];
	assign res.frame_last = last_q[LANE_LAT-1];
	assign res.edge_red   = mag[0];
	assign res.edge_green = mag[1];
	assign res.edge_blue  = mag[2];

`ifndef SYNTHESIS
	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_done_q |-> (full_q || hm1_q == '0))
		else $error("frame input complete without full lag on a multi-row frame");

	a_owe_single_row: assert property (@(posedge clk) disable iff (!arst_n)
		owe_q |-> (full_q && hm1_q == '0))
		else $error("inserted drain push outside a one-row frame");

	a_out_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_row_q <= hm1_q)
		else $error("output row ran past the frame");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sobel_edge_magnitude_rgb: random frames through the valid/ready
// channels, register writes through the APB port, results checked against an in-bench model.
// Depends on sem_pkg, sem_if and the RTL of the block.
module tb;
	import sem_pkg::*;

	localparam int LIMIT     = 1_000_000;
	localparam int ITEMS     = 1600;
	localparam int SETTLE    = 40;

	typedef enum logic { REQ_PIXEL = 1'b0, REQ_DRAIN = 1'b1 } req_e;

	typedef struct packed {
		logic       req_type;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_beat_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       frame_last;
	} edge_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sem_pix_if pix_ch();
	sem_res_if res_ch();

	sobel_edge_magnitude_rgb uut (
		.clk(clk), .arst_n(arst_n), .pix(pix_ch), .res(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// model of the block: four-row ring, registers and frame positions
	logic [23:0] row_ring [4][1024];
	int unsigned width_reg, height_reg, taken_pos, given_pos;

	pix_beat_t  pending_beats[$];
	edge_beat_t expected_edges[$];

	int  cycles, mismatches, results_seen, frames_done, items_sent;
	bit  quiet;
	bit  pix_took;
	int  send_gap, recv_gap;

	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > 1024) return 1024;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg == 0) return 1;
		if (height_reg > 4096) return 4096;
		return height_reg;
	endfunction

	function automatic logic [7:0] rounded_root(int gx, int gy);
		int unsigned s, r, t;
		s = gx * gx + gy * gy;
		r = 0;
		if (s > 255 * 254) return 8'd255;
		for (int b = 128; b != 0; b = b >> 1) begin
			t = r | b;
			if (t * (t - 1) < s) r = t;
		end
		return r[7:0];
	endfunction

	task automatic predict_edge();
		int unsigned w, h, n, o;
		int ro, co, rr, cc, v, kx, ky;
		int gx[3], gy[3];
		logic [23:0] p;
		edge_beat_t e;
		w = eff_width();
		h = eff_height();
		n = w * h;
		o = given_pos;
		ro = o / w;
		co = o % w;
		gx = '{0, 0, 0};
		gy = '{0, 0, 0};
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				rr = ro + dr - 1;
				cc = co + dc - 1;
				p = (rr < 0 || cc < 0 || rr >= h || cc >= w) ? 24'd0 : row_ring[rr & 3][cc];
				kx = (dc - 1) * ((dr == 1) ? 2 : 1);
				ky = (dr - 1) * ((dc == 1) ? 2 : 1);
				for (int ch = 0; ch < 3; ch++) begin
					v = (p >> (16 - 8 * ch)) & 8'hFF;
					gx[ch] += kx * v;
					gy[ch] += ky * v;
				end
			end
		end
		e.edge_red   = rounded_root(gx[0], gy[0]);
		e.edge_green = rounded_root(gx[1], gy[1]);
		e.edge_blue  = rounded_root(gx[2], gy[2]);
		e.frame_last = (o + 1 == n);
		expected_edges.push_back(e);
		given_pos = o + 1;
		if (given_pos >= n) begin
			given_pos = 0;
			taken_pos = 0;
			frames_done++;
		end
	endtask

	task automatic predict_beat(pix_beat_t b);
		int unsigned w, n;
		w = eff_width();
		n = w * eff_height();
		if (b.req_type == REQ_PIXEL) begin
			if (taken_pos >= n) return;
			row_ring[(taken_pos / w) & 3][taken_pos % w] = {b.red, b.green, b.blue};
			taken_pos++;
			if (given_pos + w + 1 < taken_pos) predict_edge();
		end else if (taken_pos >= n && given_pos < n) begin
			predict_edge();
		end
	endtask

	initial begin
		clk = 1'b0;
	end
	always #1 clk = ~clk;

	// monitor: sample both channels at the rising edge
	always @(posedge clk) begin
		edge_beat_t got, want;
		pix_took <= pix_ch.valid && pix_ch.ready;
		if (arst_n && pix_ch.valid && pix_ch.ready)
			predict_beat({pix_ch.req_type, pix_ch.red, pix_ch.green, pix_ch.blue});
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = {res_ch.edge_red, res_ch.edge_green, res_ch.edge_blue, res_ch.frame_last};
			results_seen++;
			if (expected_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = expected_edges.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
							results_seen, want.edge_red, want.edge_green, want.edge_blue,
							want.frame_last, got.edge_red, got.edge_green, got.edge_blue,
							got.frame_last);
				end
			end
		end
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// pixel driver: advance on a taken beat, idle in random bursts
	always @(negedge clk) begin
		logic      nv;
		pix_beat_t nb;
		nv = pix_ch.valid && !pix_took;
		nb = {pix_ch.req_type, pix_ch.red, pix_ch.green, pix_ch.blue};
		if (arst_n && !nv) begin
			if (send_gap > 0) begin
				send_gap--;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 9);
			end else if (pending_beats.size() > 0) begin
				nb = pending_beats.pop_front();
				nv = 1'b1;
			end
		end
		pix_ch.valid    <= nv;
		pix_ch.req_type <= nb.req_type;
		pix_ch.red      <= nb.red;
		pix_ch.green    <= nb.green;
		pix_ch.blue     <= nb.blue;
	end

	// result side: stall in random bursts
	always @(negedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (recv_gap > 0) begin
			recv_gap--;
			rdy = 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			recv_gap = $urandom_range(0, 9);
			rdy = 1'b0;
		end
		res_ch.ready <= rdy;
	end

	// hold until every queued beat is taken and every result is back
	task automatic wait_idle();
		while (pending_beats.size() != 0 || pix_ch.valid || expected_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(logic regsel, int unsigned value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {regsel, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (regsel == REG_FRAME_WIDTH) width_reg = value & 32'h7FF;
		else height_reg = value & 32'h1FFF;
		taken_pos = 0;
		given_pos = 0;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		wait_idle();
		reg_write(REG_FRAME_WIDTH, w);
		reg_write(REG_FRAME_HEIGHT, h);
	endtask

	task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pending_beats.push_back({REQ_PIXEL, r, g, b});
		items_sent++;
	endtask

	task automatic push_drain();
		pending_beats.push_back({REQ_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom)});
		items_sent++;
	endtask

	function automatic logic [7:0] rand_chan(int mode);
		case (mode)
			0: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
			default: return 8'($urandom);
		endcase
	endfunction

	// one frame with random content and, now and then, stray beats
	task automatic queue_frame(bit noisy);
		int unsigned w, n, tail;
		int mode, early_at;
		w = eff_width();
		n = w * eff_height();
		mode = $urandom_range(0, 3);
		early_at = (noisy && $urandom_range(0, 1) != 0) ? $urandom_range(0, n - 1) : -1;
		for (int i = 0; i < n; i++) begin
			if (i == early_at) push_drain();
			push_pixel(rand_chan(mode), rand_chan(mode), rand_chan(mode));
		end
		if (noisy && $urandom_range(0, 1) != 0) push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		tail = (n < w + 1) ? n : w + 1;
		for (int i = 0; i < tail; i++) push_drain();
		if (noisy && $urandom_range(0, 1) != 0) push_drain();
	endtask

	initial begin
		int unsigned w, h;
		bit fresh;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		pix_ch.valid = 1'b0; pix_ch.req_type = REQ_PIXEL;
		pix_ch.red = '0; pix_ch.green = '0; pix_ch.blue = '0;
		res_ch.ready = 1'b0;
		cycles = 0; mismatches = 0; results_seen = 0; frames_done = 0; items_sent = 0;
		quiet = 1'b0; pix_took = 1'b0; send_gap = 0; recv_gap = 0;
		width_reg = RST_WIDTH; height_reg = RST_HEIGHT; taken_pos = 0; given_pos = 0;
		foreach (row_ring[i, j]) row_ring[i][j] = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero registers act as a one-pixel frame
		set_frame(0, 0);
		push_drain();
		push_pixel(8'hFF, 8'hFF, 8'hFF);
		push_drain();
		push_drain();
		// 3x3 with extreme corners, early drain, extra pixel and idle drain
		set_frame(3, 3);
		push_pixel(8'hFF, 8'h00, 8'hFF);
		push_drain();
		push_pixel(8'h00, 8'hFF, 8'h00);
		push_pixel(8'hFF, 8'hFF, 8'h00);
		push_pixel(8'h00, 8'h00, 8'hFF);
		push_pixel(8'hAA, 8'h55, 8'h01);
		push_pixel(8'hFF, 8'h80, 8'h7F);
		push_pixel(8'h00, 8'hFF, 8'hFF);
		push_pixel(8'hFF, 8'h00, 8'h00);
		push_pixel(8'h00, 8'h00, 8'h00);
		push_pixel(8'h12, 8'h34, 8'h56);
		repeat (4) push_drain();
		push_drain();

		// widest row, width above range: run past the first row, then restart by a write
		set_frame(2047, 2);
		for (int i = 0; i < 1030; i++) push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		// huge height: take a few rows, then restart by a write
		set_frame(4, 8191);
		for (int i = 0; i < 30; i++) push_pixel(8'($urandom), 8'($urandom), 8'($urandom));
		set_frame(1024, 2);
		for (int i = 0; i < 40; i++) push_pixel(8'($urandom), 8'($urandom), 8'($urandom));

		fresh = 1'b1;
		while (items_sent < ITEMS) begin
			if (items_sent > ITEMS - 200) quiet = 1'b1;
			if (fresh || $urandom_range(0, 2) == 0) begin
				fresh = 1'b0;
				w = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(1, 12);
				h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
				set_frame(w, h);
			end
			queue_frame($urandom_range(0, 3) == 0);
		end
		wait_idle();

		$display("covered %0d frames, %0d result beats, last frame size %0dx%0d",
			frames_done, results_seen, eff_width(), eff_height());
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatching result beats", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
